@@ design/hbd_pkg.sv @@
// shared types, constants and coefficient generation for the half-band decimator
package hbd_pkg;

    localparam int COEF_W = 24;
    localparam int FRAC_W = 23;
    localparam logic signed [COEF_W-1:0] COEF_CENTER = 24'sd4194304;
    localparam logic [63:0] BETA_SQ_QUARTER_Q24 = 64'd424585002;
    localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
    localparam int SERIES_TERMS = 40;

    typedef struct packed {
        logic load;
        logic push;
        logic push_second;
        logic start_center;
        logic issue_tap;
        logic finish;
    } hbd_cmd_t;

    typedef struct packed {
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } hbd_status_t;

    // shift-subtract quotient, used only while building constants
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] bessel_i0_q24(logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] msq;
        sum = 64'd1 << 24;
        term = 64'd1 << 24;
        for (int m = 1; m <= SERIES_TERMS; m++)
        begin
            msq = 64'(m) * 64'(m);
            term = udiv64((term * y) >> 24, msq);
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_entry(int hist_len, int j);
        logic [63:0] mid;
        logic [63:0] mid_sq;
        logic [63:0] ak;
        logic [63:0] y;
        logic [63:0] w;
        logic [63:0] mag;
        logic [63:0] i0_beta;
        logic [63:0] pos;
        logic signed [COEF_W-1:0] c;
        mid = 64'((hist_len - 1) >> 1);
        mid_sq = mid * mid;
        pos = 64'(2 + 2 * j);
        ak = (pos >= mid) ? (pos - mid) : (mid - pos);
        y = '0;
        i0_beta = bessel_i0_q24(BETA_SQ_QUARTER_Q24);
        if (ak * ak <= mid_sq && mid_sq != 0)
        begin
            y = udiv64(BETA_SQ_QUARTER_Q24 * (mid_sq - ak * ak) + (mid_sq >> 1), mid_sq);
        end
        w = udiv64((bessel_i0_q24(y) << 23) + (i0_beta >> 1), i0_beta);
        if (ak == 0)
        begin
            c = COEF_W'((w + 64'd1) >> 1);
        end
        else if (ak[0] == 1'b0)
        begin
            c = '0;
        end
        else
        begin
            mag = udiv64(w * INV_PI_Q32 + (ak << 31), ak << 32);
            c = (ak[1:0] == 2'd3) ? -COEF_W'(mag) : COEF_W'(mag);
        end
        return c;
    endfunction

endpackage

@@ design/hbd_ctrl.sv @@
// sequencing state machine for the half-band decimator
module hbd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hbd_pkg::hbd_status_t status,
    output hbd_pkg::hbd_cmd_t    cmd
);
    import hbd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUSH1  = 3'd1;
    localparam logic [2:0] S_PUSH2  = 3'd2;
    localparam logic [2:0] S_CENTER = 3'd3;
    localparam logic [2:0] S_TAPS   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PUSH1;
                end
            end
            S_PUSH1:
            begin
                cmd.push = 1'b1;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                cmd.push = 1'b1;
                cmd.push_second = 1'b1;
                state_next = S_CENTER;
            end
            S_CENTER:
            begin
                cmd.start_center = 1'b1;
                state_next = S_TAPS;
            end
            S_TAPS:
            begin
                cmd.issue_tap = 1'b1;
                if (status.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/hbd_datapath.sv @@
// sample history, coefficient table, multiply-accumulate and output register
module hbd_datapath #(
    parameter int CHANNELS     = 2,
    parameter int ODD_TAPS     = 67,
    parameter int HISTORY_LEN  = 135,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hbd_pkg::hbd_cmd_t              cmd,
    output hbd_pkg::hbd_status_t           status,
    input  logic                           chan,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_first,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_second,
    input  logic                           block_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           out_chan,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample,
    output logic                           out_block_end
);
    import hbd_pkg::*;

    localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW     = $clog2(HISTORY_LEN);
    localparam int FW     = $clog2(HISTORY_LEN + 1);
    localparam int JW     = $clog2(ODD_TAPS);
    localparam int DEPTH  = CHANNELS * HISTORY_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 8;
    localparam int MID    = (HISTORY_LEN - 1) / 2;

    localparam logic [PW-1:0] HL_P    = PW'(HISTORY_LEN);
    localparam logic [PW-1:0] HL_LAST = PW'(HISTORY_LEN - 1);
    localparam logic [PW-1:0] MID_P   = PW'(MID);
    localparam logic [PW-1:0] TWO_P   = PW'(2);
    localparam logic [FW-1:0] HL_F    = FW'(HISTORY_LEN);
    localparam logic [JW-1:0] J_LAST  = JW'(ODD_TAPS - 1);
    localparam logic [AW-1:0] HL_A    = AW'(HISTORY_LEN);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [COEF_W-1:0] rom_tab [ODD_TAPS];

    for (genvar g = 0; g < ODD_TAPS; g++)
    begin : g_rom
        localparam logic signed [COEF_W-1:0] C = coef_entry(HISTORY_LEN, g);
        assign rom_tab[g] = C;
    end

    logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

    logic [CHW-1:0]                ch_reg;
    logic                          chan_reg;
    logic                          be_reg;
    logic signed [SAMPLE_WIDTH-1:0] first_reg;
    logic signed [SAMPLE_WIDTH-1:0] second_reg;
    logic [PW-1:0]                 wp_reg [CHANNELS];
    logic [FW-1:0]                 fill_reg [CHANNELS];
    logic [PW-1:0]                 tap_ptr_reg;
    logic [JW-1:0]                 j_reg;

    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic signed [COEF_W-1:0]       coef1_reg;
    logic                           ok1_reg;
    logic                           v1_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           v2_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    logic                           out_valid_reg;
    logic                           out_chan_reg;
    logic                           out_be_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;

    logic [PW-1:0]  wp_cur;
    logic [FW-1:0]  fill_cur;
    logic [PW-1:0]  wp_inc;
    logic [PW-1:0]  center_idx;
    logic [PW-1:0]  tap_start;
    logic [PW-1:0]  tap_dec;
    logic [PW-1:0]  rd_idx;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           issue;
    logic           rd_ok;
    logic signed [COEF_W-1:0]       rd_coef;
    logic signed [SAMPLE_WIDTH-1:0] wr_data;
    logic signed [SAMPLE_WIDTH-1:0] rd_masked;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        rounded;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;
    logic                           out_free;

    always_comb
    begin
        wp_cur = wp_reg[ch_reg];
        fill_cur = fill_reg[ch_reg];
        wp_inc = (wp_cur == HL_LAST) ? '0 : wp_cur + PW'(1);
        center_idx = (wp_cur >= MID_P) ? wp_cur - MID_P : wp_cur + (HL_P - MID_P);
        tap_start = (wp_cur >= TWO_P) ? wp_cur - TWO_P : wp_cur + (HL_P - TWO_P);
        tap_dec = (tap_ptr_reg >= TWO_P) ? tap_ptr_reg - TWO_P
                                         : tap_ptr_reg + (HL_P - TWO_P);
        issue = cmd.start_center | cmd.issue_tap;
        rd_idx = cmd.start_center ? center_idx : tap_ptr_reg;
        rd_addr = AW'(ch_reg) * HL_A + AW'(rd_idx);
        wr_addr = AW'(ch_reg) * HL_A + AW'(wp_inc);
        rd_ok = (fill_cur == HL_F) || ((rd_idx != '0) && (FW'(rd_idx) <= fill_cur));
        rd_coef = cmd.start_center ? COEF_CENTER : rom_tab[j_reg];
        wr_data = cmd.push_second ? second_reg : first_reg;
        rd_masked = ok1_reg ? rd_data_reg : '0;
        prod_next = PROD_W'(rd_masked) * PROD_W'(coef1_reg);
        rounded = (acc_reg + ROUND_HALF) >>> FRAC_W;
        if (rounded > SAT_MAX)
        begin
            sat_val = SAMPLE_WIDTH'(SAT_MAX);
        end
        else if (rounded < SAT_MIN)
        begin
            sat_val = SAMPLE_WIDTH'(SAT_MIN);
        end
        else
        begin
            sat_val = SAMPLE_WIDTH'(rounded);
        end
        out_free = !out_valid_reg || !out_stall;
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= (CHANNELS > 1) ? CHW'(chan) : '0;
            chan_reg <= chan;
            be_reg <= block_end;
            first_reg <= sample_first;
            second_reg <= sample_second;
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.start_center)
        begin
            tap_ptr_reg <= tap_start;
            j_reg <= '0;
        end
        else if (cmd.issue_tap)
        begin
            tap_ptr_reg <= tap_dec;
            j_reg <= (j_reg == J_LAST) ? j_reg : j_reg + JW'(1);
        end
        coef1_reg <= rd_coef;
        ok1_reg <= rd_ok;
        prod_reg <= prod_next;
        if (cmd.finish)
        begin
            out_chan_reg <= chan_reg;
            out_be_reg <= be_reg;
            out_sample_reg <= sat_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                wp_reg[ch_reg] <= wp_inc;
                fill_reg[ch_reg] <= (fill_cur == HL_F) ? fill_cur : fill_cur + FW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.tap_last = (j_reg == J_LAST);
    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign out_chan = out_chan_reg;
    assign out_sample = out_sample_reg;
    assign out_block_end = out_be_reg;

endmodule

@@ design/halfband_decimator_by_two.sv @@
// half-band FIR decimator by two: each input pair for a channel gives one filtered
// sample. One history memory read and one multiply-accumulate per cycle while the
// center and odd taps are read. After a transfer the block writes the pair into
// history, reads the center tap, reads the ODD_TAPS odd taps, drains the multiply
// pipeline and rounds, and waits for the output register to be free before the
// next possible transfer. A finished sample waits in the output register while
// the next pair is filtered. History starts as zeros through a per-channel fill
// count, so no clearing pass runs after reset.
module halfband_decimator_by_two #(
    parameter int CHANNELS     = 2,
    parameter int ODD_TAPS     = 67,
    parameter int HISTORY_LEN  = 135,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           chan,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_first,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_second,
    input  logic                           block_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           out_chan,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample,
    output logic                           out_block_end
);
    import hbd_pkg::*;

    hbd_cmd_t    cmd;
    hbd_status_t status;

    hbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hbd_datapath #(
        .CHANNELS     (CHANNELS),
        .ODD_TAPS     (ODD_TAPS),
        .HISTORY_LEN  (HISTORY_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .chan          (chan),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_chan      (out_chan),
        .out_sample    (out_sample),
        .out_block_end (out_block_end)
    );

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result written over a pending transfer");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.pipe_busy)
        else $error("result taken before accumulation drained");

    a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue_tap && status.tap_last) |=> !cmd.issue_tap)
        else $error("tap read issued past the last coefficient");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && cmd.push))
        else $error("transfer not followed by history write");

endmodule

@@ test/testbench.sv @@
// testbench for the half-band decimator: directed and random pairs checked by a built-in predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH = 2;
    localparam int ODD = 67;
    localparam int HLEN = 135;
    localparam int SW = 24;
    localparam int MID = (HLEN - 1) / 2;
    localparam int ITEMS = 800;
    localparam int LIMIT = 1500000;
    localparam int SHOW_MAX = 25;
    localparam longint unsigned KAISER_Y_Q24 = 64'd424585002;
    localparam longint unsigned RECIP_PI_Q32 = 64'd1367130551;
    localparam int BESSEL_TERMS = 40;
    localparam logic signed [SW-1:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] SMIN = 24'sh800000;

    typedef struct {
        logic                 chan;
        logic signed [SW-1:0] sample;
        logic                 blk;
    } decim_out_t;

    class halfband_predictor;
        int                   taps[ODD];
        logic signed [SW-1:0] hist[CH][HLEN];
        int unsigned          wp[CH];
        decim_out_t           pending[$];
        int                   errors;
        int                   checked;
        int                   clamped;

        function new();
            for (int c = 0; c < CH; c++)
            begin
                wp[c] = 0;
                for (int i = 0; i < HLEN; i++)
                    hist[c][i] = '0;
            end
            errors = 0;
            checked = 0;
            clamped = 0;
            build_taps();
        endfunction

        function longint unsigned bessel_q24(longint unsigned y);
            longint unsigned total;
            longint unsigned term;
            total = 64'd1 << 24;
            term = 64'd1 << 24;
            for (int m = 1; m <= BESSEL_TERMS; m++)
            begin
                term = ((term * y) >> 24) / longint'(m * m);
                total = total + term;
            end
            return total;
        endfunction

        // kaiser-windowed half-band taps at even positions of the delay line
        function void build_taps();
            longint unsigned mid_sq;
            longint unsigned ak;
            longint unsigned y;
            longint unsigned w;
            longint unsigned mag;
            longint unsigned i0_ref;
            longint unsigned pos;
            longint unsigned mid_u;
            mid_u = longint'(MID);
            mid_sq = mid_u * mid_u;
            i0_ref = bessel_q24(KAISER_Y_Q24);
            for (int j = 0; j < ODD; j++)
            begin
                pos = longint'(2 + 2 * j);
                ak = (pos >= mid_u) ? pos - mid_u : mid_u - pos;
                y = 0;
                if (ak * ak <= mid_sq)
                    y = (KAISER_Y_Q24 * (mid_sq - ak * ak) + mid_sq / 2) / mid_sq;
                w = ((bessel_q24(y) << 23) + i0_ref / 2) / i0_ref;
                if (ak == 0)
                    taps[j] = int'((w + 1) / 2);
                else if (ak[0] == 1'b0)
                    taps[j] = 0;
                else
                begin
                    mag = (w * RECIP_PI_Q32 + (ak << 31)) / (ak << 32);
                    taps[j] = (ak[1:0] == 2'd3) ? -int'(mag) : int'(mag);
                end
            end
        endfunction

        function void push(int c, logic signed [SW-1:0] s);
            wp[c] = (wp[c] + 1 >= HLEN) ? 0 : wp[c] + 1;
            hist[c][wp[c]] = s;
        endfunction

        function longint delayed(int c, int back);
            return longint'(hist[c][(wp[c] + HLEN - back) % HLEN]);
        endfunction

        function void note_pair(logic c, logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                logic be);
            longint acc;
            longint q;
            decim_out_t r;
            push(c, a);
            push(c, b);
            acc = delayed(c, MID) * 64'sd4194304;
            for (int j = 0; j < ODD; j++)
                acc = acc + longint'(taps[j]) * delayed(c, 2 + 2 * j);
            q = (acc + 64'sd4194304) >>> 23;
            if (q >= longint'(SMAX))
            begin
                q = longint'(SMAX);
                clamped++;
            end
            else if (q <= longint'(SMIN))
            begin
                q = longint'(SMIN);
                clamped++;
            end
            r.chan = c;
            r.sample = q[SW-1:0];
            r.blk = be;
            pending.push_back(r);
        endfunction

        task report(string msg);
            if (errors < SHOW_MAX)
                $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_output(logic c, logic signed [SW-1:0] s, logic be);
            decim_out_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("output transfer with none pending: chan %0d sample %0d", c, s));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (c !== want.chan)
                report($sformatf("out_chan got %b want %b", c, want.chan));
            if (s !== want.sample)
                report($sformatf("out_sample got %0d want %0d (chan %0d)", s, want.sample,
                                 want.chan));
            if (be !== want.blk)
                report($sformatf("out_block_end got %b want %b", be, want.blk));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 chan;
    logic signed [SW-1:0] sample_first;
    logic signed [SW-1:0] sample_second;
    logic                 block_end;
    logic                 out_valid;
    logic                 out_stall;
    logic                 out_chan;
    logic signed [SW-1:0] out_sample;
    logic                 out_block_end;

    halfband_predictor pred;
    bit                steady;
    int                sent;
    int                cycles;

    halfband_decimator_by_two #(
        .CHANNELS(CH),
        .ODD_TAPS(ODD),
        .HISTORY_LEN(HLEN),
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .chan(chan),
        .sample_first(sample_first),
        .sample_second(sample_second),
        .block_end(block_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_chan(out_chan),
        .out_sample(out_sample),
        .out_block_end(out_block_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 160);
    endfunction

    task send_pair(logic c, logic signed [SW-1:0] a, logic signed [SW-1:0] b, logic be);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        chan <= c;
        sample_first <= a;
        sample_second <= b;
        block_end <= be;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // transfer monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                pred.check_output(out_chan, out_sample, out_block_end);
            if (in_valid && !in_stall)
                pred.note_pair(chan, sample_first, sample_second, block_end);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("cycle limit reached with %0d results pending", pred.pending.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = steady ? 0 : idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        logic signed [SW-1:0] corner[5];
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic                 c;
        bit                   pol;
        int                   kind;
        int                   len;
        int                   per;
        cycles = 0;
        sent = 0;
        steady = 1'b0;
        pred = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        chan <= 1'b0;
        sample_first <= '0;
        sample_second <= '0;
        block_end <= 1'b0;
        corner[0] = SMAX;
        corner[1] = SMIN;
        corner[2] = '0;
        corner[3] = 24'sd1;
        corner[4] = -24'sd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes on both channels
        for (int ch = 0; ch < CH; ch++)
            for (int i = 0; i < 5; i++)
            begin
                send_pair(ch[0], corner[i], corner[i], i[0]);
                send_pair(ch[0], corner[i], corner[(i + 2) % 5], ~i[0]);
            end

        while (sent < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            steady = ($urandom_range(0, 4) == 0);
            c = 1'($urandom_range(0, 1));
            case (kind)
                0, 1, 2:
                begin
                    len = $urandom_range(1, 40);
                    for (int i = 0; i < len; i++)
                    begin
                        a = SW'($urandom);
                        b = SW'($urandom);
                        send_pair(1'($urandom_range(0, 1)), a, b, $urandom_range(0, 7) == 0);
                    end
                end
                3, 4:
                begin
                    // signs matched to the taps so the last output lands at the clamp
                    pol = $urandom_range(0, 1);
                    hi = SW'($urandom_range(6000000, 8388607));
                    lo = -hi - 24'sd1;
                    for (int i = MID; i >= 0; i--)
                    begin
                        a = pol ? hi : lo;
                        if (i == 0)
                            b = SW'($urandom);
                        else
                            b = ((pred.taps[i - 1] >= 0) == pol) ? hi : lo;
                        send_pair(c, a, b, i == 0);
                    end
                end
                5:
                begin
                    per = $urandom_range(0, 2);
                    v = (per == 0) ? SMAX : (per == 1) ? SMIN : 24'($urandom);
                    len = $urandom_range(10, 80);
                    for (int i = 0; i < len; i++)
                        send_pair(c, v, v, i == len - 1);
                end
                6:
                begin
                    len = $urandom_range(1, 40);
                    for (int i = 0; i < len; i++)
                    begin
                        a = SW'(int'($urandom_range(0, 511)) - 256);
                        b = SW'(int'($urandom_range(0, 511)) - 256);
                        send_pair(1'($urandom_range(0, 1)), a, b, $urandom_range(0, 7) == 0);
                    end
                end
                default:
                begin
                    // square wave of random period and amplitude
                    per = $urandom_range(1, 40);
                    hi = SW'($urandom_range(0, 8388607));
                    v = hi;
                    len = $urandom_range(20, 100);
                    for (int i = 0; i < len; i++)
                    begin
                        if (i % per == 0)
                            v = (v == hi) ? -hi - 24'sd1 : hi;
                        send_pair(c, v, v, $urandom_range(0, 15) == 0);
                    end
                end
            endcase
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (pred.pending.size() != 0)
            @(posedge clk);
        repeat (4 * ODD) @(posedge clk);

        $display("%0d pairs sent over both channels, %0d decimated samples checked",
                 sent, pred.checked);
        $display("%0d samples clamped at full scale, %0d mismatches", pred.clamped, pred.errors);
        if (pred.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
